@@ hdl/cmoe_pkg.sv @@
package cmoe_pkg;

  typedef enum logic [4:0] {
    OP_IMM     = 5'd0,
    OP_ABS     = 5'd1,
    OP_ABS_NRD = 5'd2,
    OP_PSET    = 5'd3,
    OP_PUNSET  = 5'd4,
    OP_TAX     = 5'd5,
    OP_TAY     = 5'd6,
    OP_TSX     = 5'd7,
    OP_TXA     = 5'd8,
    OP_TXS     = 5'd9,
    OP_TYA     = 5'd10,
    OP_BSET    = 5'd11,
    OP_BUNSET  = 5'd12,
    OP_STA     = 5'd13,
    OP_LDA     = 5'd14,
    OP_LDX     = 5'd15,
    OP_LDY     = 5'd16
  } opcode_e;

  localparam logic [7:0] SignBit = 8'h80;
  localparam logic [7:0] ZeroBit = 8'h02;

  typedef struct packed {
    logic        [4:0]  opcode;
    logic        [1:0]  length;
    logic        [15:0] payload;
    logic signed [7:0]  branch_offset;
    logic        [7:0]  read_data;
  } op_item_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic [7:0]  acc_out;
    logic [7:0]  xreg_out;
    logic [7:0]  yreg_out;
    logic [7:0]  stack_out;
    logic [7:0]  status_out;
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_byte;
    logic        read_valid;
    logic [15:0] read_addr;
    logic        unknown_op;
  } res_item_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic [7:0]  oper;
    logic [15:0] addr;
  } arch_t;

endpackage

@@ hdl/cmoe_op_if.sv @@
interface cmoe_op_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [1:0]  length;
  logic [15:0] payload;
  logic signed [7:0] branch_offset;
  logic [7:0]  read_data;

  modport source (
    output valid, opcode, length, payload, branch_offset, read_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, length, payload, branch_offset, read_data,
    output ready
  );
endinterface

@@ hdl/cmoe_res_if.sv @@
interface cmoe_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_out;
  logic [7:0]  acc_out;
  logic [7:0]  xreg_out;
  logic [7:0]  yreg_out;
  logic [7:0]  stack_out;
  logic [7:0]  status_out;
  logic        write_valid;
  logic [15:0] write_addr;
  logic [7:0]  write_byte;
  logic        read_valid;
  logic [15:0] read_addr;
  logic        unknown_op;

  modport source (
    output valid, pc_out, acc_out, xreg_out, yreg_out, stack_out, status_out,
           write_valid, write_addr, write_byte, read_valid, read_addr, unknown_op,
    input  ready
  );
  modport sink (
    input  valid, pc_out, acc_out, xreg_out, yreg_out, stack_out, status_out,
           write_valid, write_addr, write_byte, read_valid, read_addr, unknown_op,
    output ready
  );
endinterface

@@ hdl/cpu_micro_op_executor.sv @@
// Micro-op executor for an 8-bit CPU core.
// op_i:  one word per micro-op (opcode, length, payload, branch_offset,
//        read_data), valid/ready handshake.
// res_o: one word per micro-op with the register file after the op and
//        the memory read/write it implied, valid/ready handshake.
// A word accepted on op_i moves through the input register, then the
// result register onto res_o. Throughput: one micro-op per cycle while
// res_o.ready is high; the input and result registers let a new word enter
// while the previous result waits. The architectural registers update as
// the op enters the result register; the next op sees them with no bubble.
// Reset: PC, A, X, Y, S, P and both latches clear to zero; both stages
// come up empty.
// Stall: while res_o.ready is low the result holds, one more word is taken
// into the input register, then op_i.ready drops until the result drains.
module cpu_micro_op_executor (
  input  logic            clk_i,
  input  logic            rst_ni,
  cmoe_op_if.sink         op_i,
  cmoe_res_if.source      res_o
);

  logic                  in_valid_q, in_valid_d;
  cmoe_pkg::op_item_t    in_item_q;
  logic                  out_valid_q, out_valid_d;
  cmoe_pkg::res_item_t   out_q, out_d;
  cmoe_pkg::arch_t       st_q, st_d;
  logic                  take, advance;

  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign op_i.ready = !in_valid_q || advance;
  assign take       = op_i.valid && op_i.ready;

  assign in_valid_d  = take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !res_o.ready);

  cmoe_exec u_exec (
    .st_i     (st_q),
    .item_i   (in_item_q),
    .st_nxt_o (st_d),
    .res_o    (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q.opcode        <= op_i.opcode;
      in_item_q.length        <= op_i.length;
      in_item_q.payload       <= op_i.payload;
      in_item_q.branch_offset <= op_i.branch_offset;
      in_item_q.read_data     <= op_i.read_data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pc_out      = out_q.pc_out;
  assign res_o.acc_out     = out_q.acc_out;
  assign res_o.xreg_out    = out_q.xreg_out;
  assign res_o.yreg_out    = out_q.yreg_out;
  assign res_o.stack_out   = out_q.stack_out;
  assign res_o.status_out  = out_q.status_out;
  assign res_o.write_valid = out_q.write_valid;
  assign res_o.write_addr  = out_q.write_addr;
  assign res_o.write_byte  = out_q.write_byte;
  assign res_o.read_valid  = out_q.read_valid;
  assign res_o.read_addr   = out_q.read_addr;
  assign res_o.unknown_op  = out_q.unknown_op;

endmodule

@@ hdl/cmoe_exec.sv @@
module cmoe_exec (
  input  cmoe_pkg::arch_t     st_i,
  input  cmoe_pkg::op_item_t  item_i,
  output cmoe_pkg::arch_t     st_nxt_o,
  output cmoe_pkg::res_item_t res_o
);

  function automatic logic [7:0] nz_flags(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r = f & ~(cmoe_pkg::SignBit | cmoe_pkg::ZeroBit);
    r = r | (v & cmoe_pkg::SignBit);
    if (v == 8'h00) begin
      r = r | cmoe_pkg::ZeroBit;
    end
    return r;
  endfunction

  logic [7:0]  mask;
  logic [15:0] pc_adv;
  logic [15:0] disp;
  logic [15:0] pc_br;
  logic        flag_hit;

  assign mask     = item_i.payload[7:0];
  assign pc_adv   = st_i.pc + {14'd0, item_i.length};
  assign disp     = {{8{item_i.branch_offset[7]}}, item_i.branch_offset};
  assign pc_br    = pc_adv + disp;
  assign flag_hit = |(st_i.flags & mask);

  cmoe_pkg::arch_t nxt;
  logic        wv, rv, unk;
  logic [15:0] wa, ra;
  logic [7:0]  wb;

  always_comb begin
    nxt    = st_i;
    nxt.pc = pc_adv;
    wv  = 1'b0;
    wa  = 16'd0;
    wb  = 8'd0;
    rv  = 1'b0;
    ra  = 16'd0;
    unk = 1'b0;
    case (item_i.opcode)
      cmoe_pkg::OP_IMM: begin
        nxt.oper = mask;
      end
      cmoe_pkg::OP_ABS: begin
        nxt.addr = item_i.payload;
        nxt.oper = item_i.read_data;
        rv = 1'b1;
        ra = item_i.payload;
      end
      cmoe_pkg::OP_ABS_NRD: begin
        nxt.addr = item_i.payload;
      end
      cmoe_pkg::OP_PSET: begin
        nxt.flags = st_i.flags | mask;
      end
      cmoe_pkg::OP_PUNSET: begin
        nxt.flags = st_i.flags & ~mask;
      end
      cmoe_pkg::OP_TAX: begin
        nxt.oper  = st_i.acc;
        nxt.x     = st_i.acc;
        nxt.flags = nz_flags(st_i.flags, st_i.acc);
      end
      cmoe_pkg::OP_TAY: begin
        nxt.oper  = st_i.acc;
        nxt.y     = st_i.acc;
        nxt.flags = nz_flags(st_i.flags, st_i.acc);
      end
      cmoe_pkg::OP_TSX: begin
        nxt.oper  = st_i.sp;
        nxt.x     = st_i.sp;
        nxt.flags = nz_flags(st_i.flags, st_i.sp);
      end
      cmoe_pkg::OP_TXA: begin
        nxt.oper  = st_i.x;
        nxt.acc   = st_i.x;
        nxt.flags = nz_flags(st_i.flags, st_i.x);
      end
      cmoe_pkg::OP_TXS: begin
        nxt.oper = st_i.x;
        nxt.sp   = st_i.x;
      end
      cmoe_pkg::OP_TYA: begin
        nxt.oper  = st_i.y;
        nxt.acc   = st_i.y;
        nxt.flags = nz_flags(st_i.flags, st_i.y);
      end
      cmoe_pkg::OP_BSET: begin
        if (flag_hit) begin
          nxt.pc = pc_br;
        end
      end
      cmoe_pkg::OP_BUNSET: begin
        if (!flag_hit) begin
          nxt.pc = pc_br;
        end
      end
      cmoe_pkg::OP_STA: begin
        wv = 1'b1;
        wa = st_i.addr;
        wb = st_i.acc;
      end
      cmoe_pkg::OP_LDA: begin
        nxt.acc   = st_i.oper;
        nxt.flags = nz_flags(st_i.flags, st_i.oper);
      end
      cmoe_pkg::OP_LDX: begin
        nxt.x     = st_i.oper;
        nxt.flags = nz_flags(st_i.flags, st_i.oper);
      end
      cmoe_pkg::OP_LDY: begin
        nxt.y     = st_i.oper;
        nxt.flags = nz_flags(st_i.flags, st_i.oper);
      end
      default: begin
        // unrecognized op: state untouched, pc not advanced
        nxt = st_i;
        unk = 1'b1;
      end
    endcase
  end

  assign st_nxt_o = nxt;

  always_comb begin
    res_o.pc_out      = nxt.pc;
    res_o.acc_out     = nxt.acc;
    res_o.xreg_out    = nxt.x;
    res_o.yreg_out    = nxt.y;
    res_o.stack_out   = nxt.sp;
    res_o.status_out  = nxt.flags;
    res_o.write_valid = wv;
    res_o.write_addr  = wa;
    res_o.write_byte  = wb;
    res_o.read_valid  = rv;
    res_o.read_addr   = ra;
    res_o.unknown_op  = unk;
  end

endmodule

@@ hdl/cmoe_checker.sv @@
module cmoe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [15:0] pc_out_i,
  input logic [7:0]  acc_out_i,
  input logic [7:0]  status_out_i,
  input logic        write_valid_i,
  input logic [15:0] write_addr_i,
  input logic [7:0]  write_byte_i,
  input logic        read_valid_i,
  input logic [15:0] read_addr_i,
  input logic        unknown_op_i
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(pc_out_i) && $stable(acc_out_i) && $stable(status_out_i))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  a_unk_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && unknown_op_i |->
      !write_valid_i && !read_valid_i && write_addr_i == 16'd0 && read_addr_i == 16'd0)
    else $error("unknown op produced a memory access");

  a_sta_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && write_valid_i |-> write_byte_i == acc_out_i && !read_valid_i)
    else $error("store byte differs from accumulator");

  a_no_access_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !write_valid_i |-> write_addr_i == 16'd0 && write_byte_i == 8'd0)
    else $error("write fields set without a store");

endmodule

bind cpu_micro_op_executor cmoe_checker u_cmoe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .pc_out_i      (res_o.pc_out),
  .acc_out_i     (res_o.acc_out),
  .status_out_i  (res_o.status_out),
  .write_valid_i (res_o.write_valid),
  .write_addr_i  (res_o.write_addr),
  .write_byte_i  (res_o.write_byte),
  .read_valid_i  (res_o.read_valid),
  .read_addr_i   (res_o.read_addr),
  .unknown_op_i  (res_o.unknown_op)
);
